@@ rtl/core/dast_pkg.sv @@
// Shared types, constants and a helper function of the alignment core.
package dast_pkg;

	localparam int MAX_LEN = 256;
	localparam int LEN_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = LEN_W + 1;
	localparam int ALN_W   = CNT_W + 1;
	localparam int SCORE_W = 19;
	localparam int SYM_W   = 3;
	localparam logic [SYM_W-1:0] SYM_GAP = 3'd4;

	typedef enum logic [2:0] {
		OP_LOAD_LONG  = 3'd0,
		OP_LOAD_SHORT = 3'd1,
		OP_ALIGN      = 3'd2,
		OP_READ       = 3'd3,
		OP_CLEAR      = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_OVF   = 2'd2,
		STAT_NONE  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_SUMMARY = 1'b0,
		KIND_COLUMN  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_GAP    = 2'd0,
		REG_W_AT   = 2'd1,
		REG_W_GC   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PTR_DIAG = 2'd0,
		PTR_LEFT = 2'd1,
		PTR_UP   = 2'd2
	} ptr_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_ROW_RD, ST_ROW_WR, ST_CELL_RD, ST_CELL_WR,
		ST_TRACE_RD, ST_TRACE_WR, ST_SUMMARY, ST_READ_OUT
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD_LONG, DP_LOAD_SHORT, DP_CLEAR, DP_ALIGN_START, DP_INIT,
		DP_ROW_RD, DP_ROW_WR, DP_CELL_RD, DP_CELL_WR, DP_TRACE_RD, DP_TRACE_WR,
		DP_SUMMARY, DP_READ_RD, DP_COLUMN
	} dp_op_t;

	typedef struct packed {
		logic init_last;
		logic cell_end;
		logic row_last;
		logic trace_done;
		logic empty;
		logic out_free;
	} dp_status_t;

	// Signed weight for a short-sequence row base and a long-sequence column base.
	function automatic logic signed [7:0] weight_of(logic [63:0] w_at, logic [63:0] w_gc,
			logic [1:0] row, logic [1:0] col);
		logic [3:0]  idx;
		logic [63:0] sel;
		idx = {row, col};
		sel = idx[3] ? w_gc : w_at;
		return $signed(sel[idx[2:0]*8 +: 8]);
	endfunction

endpackage

@@ rtl/core/dast_if.sv @@
// Handshake channel interfaces for requests, results and register writes.
interface dast_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [1:0] base;
	modport source (output valid, opcode, base, input ready);
	modport sink (input valid, opcode, base, output ready);
endinterface

interface dast_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  status;
	logic signed [18:0] best_score;
	logic [8:0]  best_row;
	logic [8:0]  best_col;
	logic [9:0]  align_length;
	logic [2:0]  long_symbol;
	logic [2:0]  short_symbol;
	logic        last_column;
	modport source (output valid, kind, status, best_score, best_row, best_col,
		align_length, long_symbol, short_symbol, last_column, input ready);
	modport sink (input valid, kind, status, best_score, best_row, best_col,
		align_length, long_symbol, short_symbol, last_column, output ready);
endinterface

interface dast_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/core/dast_ctrl.sv @@
// Sequencing state machine of the alignment core.
module dast_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	dast_cmd_if.sink              cmd,
	input  dast_pkg::dp_status_t  stat,
	output dast_pkg::dp_op_t      op,
	output dast_pkg::state_t      state
);

	dast_pkg::state_t state_q, state_d;
	logic acc;

	assign cmd.ready = (state_q == dast_pkg::ST_IDLE);
	assign acc = cmd.valid && cmd.ready;
	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dast_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dast_pkg::ST_IDLE: begin
				if (acc && cmd.opcode == dast_pkg::OP_ALIGN) begin
					state_d = stat.empty ? dast_pkg::ST_SUMMARY : dast_pkg::ST_INIT;
				end else if (acc && cmd.opcode == dast_pkg::OP_READ) begin
					state_d = dast_pkg::ST_READ_OUT;
				end
			end
			dast_pkg::ST_INIT: begin
				if (stat.init_last) state_d = dast_pkg::ST_ROW_RD;
			end
			dast_pkg::ST_ROW_RD:  state_d = dast_pkg::ST_ROW_WR;
			dast_pkg::ST_ROW_WR:  state_d = dast_pkg::ST_CELL_RD;
			dast_pkg::ST_CELL_RD: state_d = dast_pkg::ST_CELL_WR;
			dast_pkg::ST_CELL_WR: begin
				if (!stat.cell_end) state_d = dast_pkg::ST_CELL_RD;
				else if (stat.row_last) state_d = dast_pkg::ST_TRACE_RD;
				else state_d = dast_pkg::ST_ROW_RD;
			end
			dast_pkg::ST_TRACE_RD: begin
				state_d = stat.trace_done ? dast_pkg::ST_SUMMARY : dast_pkg::ST_TRACE_WR;
			end
			dast_pkg::ST_TRACE_WR: state_d = dast_pkg::ST_TRACE_RD;
			dast_pkg::ST_SUMMARY, dast_pkg::ST_READ_OUT: begin
				if (stat.out_free) state_d = dast_pkg::ST_IDLE;
			end
			default: state_d = dast_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		op = dast_pkg::DP_NOP;
		case (state_q)
			dast_pkg::ST_IDLE: begin
				if (acc) begin
					case (cmd.opcode)
						dast_pkg::OP_LOAD_LONG:  op = dast_pkg::DP_LOAD_LONG;
						dast_pkg::OP_LOAD_SHORT: op = dast_pkg::DP_LOAD_SHORT;
						dast_pkg::OP_ALIGN:      op = dast_pkg::DP_ALIGN_START;
						dast_pkg::OP_READ:       op = dast_pkg::DP_READ_RD;
						dast_pkg::OP_CLEAR:      op = dast_pkg::DP_CLEAR;
						default:                 op = dast_pkg::DP_NOP;
					endcase
				end
			end
			dast_pkg::ST_INIT:     op = dast_pkg::DP_INIT;
			dast_pkg::ST_ROW_RD:   op = dast_pkg::DP_ROW_RD;
			dast_pkg::ST_ROW_WR:   op = dast_pkg::DP_ROW_WR;
			dast_pkg::ST_CELL_RD:  op = dast_pkg::DP_CELL_RD;
			dast_pkg::ST_CELL_WR:  op = dast_pkg::DP_CELL_WR;
			dast_pkg::ST_TRACE_RD: begin
				if (!stat.trace_done) op = dast_pkg::DP_TRACE_RD;
			end
			dast_pkg::ST_TRACE_WR: op = dast_pkg::DP_TRACE_WR;
			dast_pkg::ST_SUMMARY: begin
				if (stat.out_free) op = dast_pkg::DP_SUMMARY;
			end
			dast_pkg::ST_READ_OUT: begin
				if (stat.out_free) op = dast_pkg::DP_COLUMN;
			end
			default: op = dast_pkg::DP_NOP;
		endcase
	end

endmodule

@@ rtl/core/dast_dp.sv @@
// Datapath: sequence, score, pointer and alignment memories with the cell arithmetic.
module dast_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dast_pkg::dp_op_t      op,
	input  logic [1:0]            base,
	output dast_pkg::dp_status_t  stat,
	dast_cfg_if.sink              cfg,
	dast_res_if.source            res
);

	localparam int LW = dast_pkg::LEN_W;
	localparam int CW = dast_pkg::CNT_W;
	localparam int AW = dast_pkg::ALN_W;
	localparam int SW = dast_pkg::SCORE_W;

	logic [1:0]    long_mem  [dast_pkg::MAX_LEN];
	logic [1:0]    short_mem [dast_pkg::MAX_LEN];
	logic [SW-1:0] prev_mem  [dast_pkg::MAX_LEN + 1];
	logic [1:0]    ptr_mem   [dast_pkg::MAX_LEN * dast_pkg::MAX_LEN];
	logic [5:0]    aln_mem   [2 * dast_pkg::MAX_LEN];

	logic [7:0]  gap_q;
	logic [63:0] w_at_q, w_gc_q;
	logic [CW-1:0] long_cnt_q, short_cnt_q, r_q, c_q, br_q, bc_q;
	logic          ovf_q, first_q;
	logic [AW-1:0] aln_cnt_q, rd_pos_q, n_q;
	logic signed [SW-1:0] acc_q, corner_q, left_q, best_q;
	logic [1:0]    sbase_q;
	logic [1:0]    long_rd_q, short_rd_q, ptr_rd_q;
	logic [SW-1:0] prev_rd_q;
	logic [5:0]    aln_rd_q;

	logic [LW-1:0] c_m1, r_m1;
	logic signed [7:0]    w;
	logic signed [SW:0]   d, l, u, v;
	logic [1:0]           p;
	logic                 take;
	logic signed [SW-1:0] best_n;
	logic [CW-1:0]        br_n, bc_n;
	logic [AW-1:0]        aln_addr;
	logic                 avail;
	logic [2:0]           ls, ss;
	logic                 out_vld_q;

	assign c_m1 = LW'(c_q - 1'b1);
	assign r_m1 = LW'(r_q - 1'b1);
	assign cfg.ready = 1'b1;

	assign stat.init_last  = (c_q == long_cnt_q);
	assign stat.cell_end   = (c_q == long_cnt_q);
	assign stat.row_last   = (r_q == short_cnt_q);
	assign stat.trace_done = (r_q == '0) && (c_q == '0);
	assign stat.empty      = (long_cnt_q == '0) || (short_cnt_q == '0);
	assign stat.out_free   = !out_vld_q || res.ready;

	// Cell recurrence; the pointer favors diagonal, then left, on ties.
	always_comb begin
		w = dast_pkg::weight_of(w_at_q, w_gc_q, sbase_q, long_rd_q);
		d = (SW+1)'(corner_q) + (SW+1)'(w);
		l = (SW+1)'(left_q) - (SW+1)'({1'b0, gap_q});
		u = (SW+1)'($signed(prev_rd_q)) - (SW+1)'({1'b0, gap_q});
		if (d > l && d > u) v = d;
		else if (l > u) v = l;
		else v = u;
		if (d >= l && d >= u) p = dast_pkg::PTR_DIAG;
		else if (l >= u) p = dast_pkg::PTR_LEFT;
		else p = dast_pkg::PTR_UP;
		take   = first_q || (best_q < SW'(v));
		best_n = take ? SW'(v) : best_q;
		br_n   = take ? r_q : br_q;
		bc_n   = take ? c_q : bc_q;
	end

	// Trace step symbols; padding once either index reaches zero.
	always_comb begin
		ls = dast_pkg::SYM_GAP;
		ss = dast_pkg::SYM_GAP;
		if (r_q != '0 && c_q != '0) begin
			case (ptr_rd_q)
				dast_pkg::PTR_DIAG: begin ls = {1'b0, long_rd_q}; ss = {1'b0, short_rd_q}; end
				dast_pkg::PTR_LEFT: ls = {1'b0, long_rd_q};
				default:            ss = {1'b0, short_rd_q};
			endcase
		end else if (r_q != '0) begin
			ss = {1'b0, short_rd_q};
		end else begin
			ls = {1'b0, long_rd_q};
		end
	end

	assign avail    = rd_pos_q < aln_cnt_q;
	assign aln_addr = aln_cnt_q - 1'b1 - rd_pos_q;

	// Memories.
	always_ff @(posedge clk) begin
		if (op == dast_pkg::DP_LOAD_LONG && !long_cnt_q[CW-1])
			long_mem[long_cnt_q[LW-1:0]] <= base;
		if (op == dast_pkg::DP_LOAD_SHORT && !short_cnt_q[CW-1])
			short_mem[short_cnt_q[LW-1:0]] <= base;
		if (op == dast_pkg::DP_CELL_RD || op == dast_pkg::DP_TRACE_RD)
			long_rd_q <= long_mem[c_m1];
		if (op == dast_pkg::DP_ROW_RD || op == dast_pkg::DP_TRACE_RD)
			short_rd_q <= short_mem[r_m1];
	end

	always_ff @(posedge clk) begin
		if (op == dast_pkg::DP_INIT)
			prev_mem[c_q] <= acc_q;
		else if (op == dast_pkg::DP_ROW_WR)
			prev_mem[0] <= acc_q;
		else if (op == dast_pkg::DP_CELL_WR)
			prev_mem[c_q] <= SW'(v);
		if (op == dast_pkg::DP_ROW_RD)
			prev_rd_q <= prev_mem[0];
		else if (op == dast_pkg::DP_CELL_RD)
			prev_rd_q <= prev_mem[c_q];
	end

	always_ff @(posedge clk) begin
		if (op == dast_pkg::DP_CELL_WR)
			ptr_mem[{r_m1, c_m1}] <= p;
		if (op == dast_pkg::DP_TRACE_RD)
			ptr_rd_q <= ptr_mem[{r_m1, c_m1}];
	end

	always_ff @(posedge clk) begin
		if (op == dast_pkg::DP_TRACE_WR)
			aln_mem[n_q[AW-2:0]] <= {ls, ss};
		if (op == dast_pkg::DP_READ_RD)
			aln_rd_q <= aln_mem[aln_addr[AW-2:0]];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= '0;
			w_at_q      <= 64'd1099511627777;
			w_gc_q      <= 64'd72057594037993472;
			long_cnt_q  <= '0;
			short_cnt_q <= '0;
			ovf_q       <= 1'b0;
			aln_cnt_q   <= '0;
			rd_pos_q    <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					dast_pkg::REG_GAP:  gap_q  <= cfg.wdata[7:0];
					dast_pkg::REG_W_AT: w_at_q <= cfg.wdata;
					dast_pkg::REG_W_GC: w_gc_q <= cfg.wdata;
					default: ;
				endcase
			end
			case (op)
				dast_pkg::DP_LOAD_LONG: begin
					if (long_cnt_q[CW-1]) ovf_q <= 1'b1;
					else long_cnt_q <= long_cnt_q + 1'b1;
				end
				dast_pkg::DP_LOAD_SHORT: begin
					if (short_cnt_q[CW-1]) ovf_q <= 1'b1;
					else short_cnt_q <= short_cnt_q + 1'b1;
				end
				dast_pkg::DP_CLEAR: begin
					long_cnt_q  <= '0;
					short_cnt_q <= '0;
					ovf_q       <= 1'b0;
					aln_cnt_q   <= '0;
					rd_pos_q    <= '0;
				end
				dast_pkg::DP_ALIGN_START: begin
					aln_cnt_q <= '0;
					rd_pos_q  <= '0;
				end
				dast_pkg::DP_SUMMARY: aln_cnt_q <= n_q;
				dast_pkg::DP_COLUMN: begin
					if (avail) rd_pos_q <= rd_pos_q + 1'b1;
				end
				default: ;
			endcase
			if (op == dast_pkg::DP_SUMMARY || op == dast_pkg::DP_COLUMN)
				out_vld_q <= 1'b1;
			else if (res.ready)
				out_vld_q <= 1'b0;
		end
	end

	// Walk registers.
	always_ff @(posedge clk) begin
		case (op)
			dast_pkg::DP_ALIGN_START: begin
				r_q <= CW'(1); c_q <= '0; acc_q <= '0; n_q <= '0;
				first_q <= 1'b1; best_q <= '0; br_q <= CW'(1); bc_q <= CW'(1);
			end
			dast_pkg::DP_INIT: begin
				c_q   <= c_q + 1'b1;
				acc_q <= stat.init_last ? -SW'(gap_q) : acc_q - SW'(gap_q);
			end
			dast_pkg::DP_ROW_WR: begin
				corner_q <= $signed(prev_rd_q);
				left_q   <= acc_q;
				acc_q    <= acc_q - SW'(gap_q);
				sbase_q  <= short_rd_q;
				c_q      <= CW'(1);
			end
			dast_pkg::DP_CELL_WR: begin
				corner_q <= $signed(prev_rd_q);
				left_q   <= SW'(v);
				best_q   <= best_n;
				br_q     <= br_n;
				bc_q     <= bc_n;
				first_q  <= 1'b0;
				if (!stat.cell_end) c_q <= c_q + 1'b1;
				else if (stat.row_last) begin r_q <= br_n; c_q <= bc_n; end
				else r_q <= r_q + 1'b1;
			end
			dast_pkg::DP_TRACE_WR: begin
				n_q <= n_q + 1'b1;
				if (ls != dast_pkg::SYM_GAP) c_q <= c_q - 1'b1;
				if (ss != dast_pkg::SYM_GAP) r_q <= r_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (op == dast_pkg::DP_SUMMARY) begin
			res.kind         <= dast_pkg::KIND_SUMMARY;
			res.status       <= stat.empty ? dast_pkg::STAT_EMPTY
				: (ovf_q ? dast_pkg::STAT_OVF : dast_pkg::STAT_OK);
			res.best_score   <= stat.empty ? '0 : best_q;
			res.best_row     <= stat.empty ? '0 : br_q;
			res.best_col     <= stat.empty ? '0 : bc_q;
			res.align_length <= n_q;
			res.long_symbol  <= '0;
			res.short_symbol <= '0;
			res.last_column  <= 1'b0;
		end else if (op == dast_pkg::DP_COLUMN) begin
			res.kind         <= dast_pkg::KIND_COLUMN;
			res.status       <= avail ? dast_pkg::STAT_OK : dast_pkg::STAT_NONE;
			res.best_score   <= '0;
			res.best_row     <= '0;
			res.best_col     <= '0;
			res.align_length <= '0;
			res.long_symbol  <= avail ? aln_rd_q[5:3] : 3'd0;
			res.short_symbol <= avail ? aln_rd_q[2:0] : 3'd0;
			res.last_column  <= avail && (rd_pos_q + 1'b1 == aln_cnt_q);
		end
	end

	assign res.valid = out_vld_q;

endmodule

@@ rtl/core/dna_alignment_score_traceback_core.sv @@
// Top level of the DNA alignment core with linear gap scoring, traced from the best cell.
// Load, clear and unused requests are taken one per cycle while the block is
// idle. An align request with an empty sequence goes straight to the summary.
// Otherwise the block writes the L+1 entries of the score row, then reads and
// writes the score row memory at each row start and for each of the S*L cells.
// The traceback then reads and writes once per alignment column, and the summary
// is loaded when the output register is free.
// A read request reads the buffer and then loads the result register.
// Results wait in an output register; the next request is taken while one
// waits, and the block stalls only when a second result is ready before the
// first one has been taken. Configuration writes are accepted in every cycle.
module dna_alignment_score_traceback_core (
	input  logic       clk,
	input  logic       arst_n,
	dast_cmd_if.sink   cmd,
	dast_res_if.source res,
	dast_cfg_if.sink   cfg
);

	dast_pkg::dp_op_t     op;
	dast_pkg::dp_status_t stat;
	dast_pkg::state_t     state;

	// The controller sequences every request; the datapath owns all storage.
	dast_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.op     (op),
		.state  (state)
	);

	dast_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.base   (cmd.base),
		.stat   (stat),
		.cfg    (cfg),
		.res    (res)
	);

	// A delivered alignment column never has a gap on both sides.
	a_no_double_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == dast_pkg::KIND_COLUMN && res.status == dast_pkg::STAT_OK
		|-> (res.long_symbol != dast_pkg::SYM_GAP || res.short_symbol != dast_pkg::SYM_GAP))
		else $error("alignment column with two gaps");

	// The alignment covers at least every base up to the best cell.
	a_len_covers: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == dast_pkg::KIND_SUMMARY && res.status != dast_pkg::STAT_EMPTY
		|-> (res.align_length >= 10'(res.best_row) && res.align_length >= 10'(res.best_col)))
		else $error("alignment shorter than best cell position");

	// An align request with both sequences loaded keeps the block busy next cycle.
	a_align_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.opcode == dast_pkg::OP_ALIGN && !stat.empty
		|=> (state == dast_pkg::ST_INIT && !cmd.ready))
		else $error("align request did not start the score walk");

endmodule

@@ test/tb_dna_alignment_score_traceback_core.sv @@
`timescale 1ns / 100ps
// Testbench of the alignment core: self-checking request and result traffic.
module tb_dna_alignment_score_traceback_core;

	localparam int  LIMIT_CYCLES = 2000000;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  HOLD_CYCLES  = 400;

	// One expected or observed result, one field per output of the result channel.
	typedef struct {
		dast_pkg::kind_t    kind;
		dast_pkg::status_t  status;
		logic signed [18:0] score;
		logic [8:0]        row;
		logic [8:0]        col;
		logic [9:0]        len;
		logic [2:0]        lsym;
		logic [2:0]        ssym;
		logic              last;
	} aln_result_t;

	logic clk;
	logic arst_n;

	dast_cmd_if cmd_ch();
	dast_res_if res_ch();
	dast_cfg_if cfg_ch();

	dna_alignment_score_traceback_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.res    (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Private copy of the block's state, advanced once per accepted request.
	logic [7:0]  gap_reg;
	logic [63:0] w_at_reg;
	logic [63:0] w_gc_reg;
	logic [1:0]  long_seq [0:dast_pkg::MAX_LEN-1];
	logic [1:0]  short_seq [0:dast_pkg::MAX_LEN-1];
	int          long_len;
	int          short_len;
	bit          overflow_seen;
	logic [2:0]  col_long [0:2*dast_pkg::MAX_LEN-1];
	logic [2:0]  col_short [0:2*dast_pkg::MAX_LEN-1];
	int          column_count;
	int          read_pos;
	int          score_row [0:dast_pkg::MAX_LEN];
	logic [1:0]  trace_ptr [0:dast_pkg::MAX_LEN*dast_pkg::MAX_LEN-1];

	aln_result_t pending_results[$];
	int          mismatch_count;
	int          cycle_count;
	bit          hold_request;
	int          burst_left;
	bit          sender_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The timeout counts every cycle of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Signed weight of a short-sequence row base against a long-sequence column base.
	function automatic int base_weight(logic [1:0] srow, logic [1:0] lcol);
		logic [3:0]  idx;
		logic [63:0] sel;
		logic [7:0]  b;
		idx = {srow, lcol};
		sel = idx[3] ? w_gc_reg : w_at_reg;
		b = sel[idx[2:0]*8 +: 8];
		return int'($signed(b));
	endfunction

	// Fills the score matrix, finds the first maximum and traces back from it.
	function automatic aln_result_t score_and_trace();
		aln_result_t r;
		int best, br, bc, row, col, corner, up, d, l, u, v, n;
		logic [1:0] p;
		r = '{dast_pkg::KIND_SUMMARY, dast_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0};
		column_count = 0;
		read_pos = 0;
		if (long_len == 0 || short_len == 0) begin
			r.status = dast_pkg::STAT_EMPTY;
			return r;
		end
		r.status = overflow_seen ? dast_pkg::STAT_OVF : dast_pkg::STAT_OK;
		for (col = 0; col <= long_len; col++)
			score_row[col] = -(col * int'(gap_reg));
		best = 0;
		br = 1;
		bc = 1;
		for (row = 1; row <= short_len; row++) begin
			corner = score_row[0];
			score_row[0] = -(row * int'(gap_reg));
			for (col = 1; col <= long_len; col++) begin
				up = score_row[col];
				d = corner + base_weight(short_seq[row-1], long_seq[col-1]);
				l = score_row[col-1] - int'(gap_reg);
				u = up - int'(gap_reg);
				v = (d > l && d > u) ? d : (l > u ? l : u);
				// Ties favor the diagonal, then the left neighbor.
				p = (d >= l && d >= u) ? dast_pkg::PTR_DIAG
					: (l >= u ? dast_pkg::PTR_LEFT : dast_pkg::PTR_UP);
				trace_ptr[(row-1)*dast_pkg::MAX_LEN + col-1] = p;
				if ((row == 1 && col == 1) || best < v) begin
					best = v;
					br = row;
					bc = col;
				end
				corner = up;
				score_row[col] = v;
			end
		end
		row = br;
		col = bc;
		n = 0;
		do begin
			p = trace_ptr[(row-1)*dast_pkg::MAX_LEN + col-1];
			if (p == dast_pkg::PTR_DIAG) begin
				col_long[n] = {1'b0, long_seq[col-1]};
				col_short[n] = {1'b0, short_seq[row-1]};
				row--;
				col--;
			end else if (p == dast_pkg::PTR_LEFT) begin
				col_long[n] = {1'b0, long_seq[col-1]};
				col_short[n] = dast_pkg::SYM_GAP;
				col--;
			end else begin
				col_long[n] = dast_pkg::SYM_GAP;
				col_short[n] = {1'b0, short_seq[row-1]};
				row--;
			end
			n++;
		end while (row > 0 && col > 0);
		// Whatever remains of either sequence is paired with gaps.
		while (row > 0) begin
			col_long[n] = dast_pkg::SYM_GAP;
			col_short[n] = {1'b0, short_seq[row-1]};
			row--;
			n++;
		end
		while (col > 0) begin
			col_long[n] = {1'b0, long_seq[col-1]};
			col_short[n] = dast_pkg::SYM_GAP;
			col--;
			n++;
		end
		column_count = n;
		if (best > 262143) best = 262143;
		if (best < -262144) best = -262144;
		r.score = 19'(best);
		r.row = 9'(br);
		r.col = 9'(bc);
		r.len = 10'(n);
		return r;
	endfunction

	// Applies one accepted request to the private state and queues its result.
	task automatic predict_request(logic [2:0] op, logic [1:0] b);
		aln_result_t r;
		case (op)
			dast_pkg::OP_LOAD_LONG: begin
				if (long_len < dast_pkg::MAX_LEN) long_seq[long_len++] = b;
				else overflow_seen = 1'b1;
			end
			dast_pkg::OP_LOAD_SHORT: begin
				if (short_len < dast_pkg::MAX_LEN) short_seq[short_len++] = b;
				else overflow_seen = 1'b1;
			end
			dast_pkg::OP_CLEAR: begin
				long_len = 0;
				short_len = 0;
				overflow_seen = 1'b0;
				column_count = 0;
				read_pos = 0;
			end
			dast_pkg::OP_ALIGN: pending_results.push_back(score_and_trace());
			dast_pkg::OP_READ: begin
				r = '{dast_pkg::KIND_COLUMN, dast_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0};
				if (read_pos < column_count) begin
					// Columns were stored from the end backward, so read them in reverse.
					r.lsym = col_long[column_count-1-read_pos];
					r.ssym = col_short[column_count-1-read_pos];
					read_pos++;
					r.last = (read_pos == column_count);
				end else begin
					r.status = dast_pkg::STAT_NONE;
				end
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Offers one request and waits until the block takes it. The valid stays high
	// through a burst and is only lowered when a gap follows.
	task automatic send_request(logic [2:0] op, logic [1:0] b);
		int gap_len;
		cmd_ch.valid  <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.base   <= b;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_request(op, b);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap_len = sender_gaps ? $urandom_range(0, 5) : 0;
			if (gap_len > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
	endtask

	// Stops offering requests until every expected result has come back, then
	// lets the block settle so that trailing load or clear requests are done.
	task automatic wait_for_drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers back to back while the block is idle.
	task automatic write_registers(logic [7:0] gap, logic [63:0] w_at, logic [63:0] w_gc);
		logic [63:0] vals [3];
		vals[0] = {56'd0, gap};
		vals[1] = w_at;
		vals[2] = w_gc;
		wait_for_drain();
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= dast_pkg::reg_idx_t'(i);
			cfg_ch.wdata <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		gap_reg = gap;
		w_at_reg = w_at;
		w_gc_reg = w_gc;
	endtask

	// One well-formed job: clear, load both sequences, align and read every column,
	// sometimes with one read past the end.
	task automatic run_alignment(int llen, int slen, bit extra_read);
		int reads;
		send_request(dast_pkg::OP_CLEAR, 2'($urandom_range(0, 3)));
		for (int i = 0; i < llen; i++)
			send_request(dast_pkg::OP_LOAD_LONG, 2'($urandom_range(0, 3)));
		for (int i = 0; i < slen; i++)
			send_request(dast_pkg::OP_LOAD_SHORT, 2'($urandom_range(0, 3)));
		send_request(dast_pkg::OP_ALIGN, 2'($urandom_range(0, 3)));
		reads = column_count + (extra_read ? 1 : 0);
		for (int i = 0; i < reads; i++)
			send_request(dast_pkg::OP_READ, 2'($urandom_range(0, 3)));
	endtask

	function automatic logic [63:0] random_weights();
		return {$urandom, $urandom};
	endfunction

	// Receiver: ready follows a random stall pattern that is redrawn now and then,
	// and a long hold-off can be requested by the pressure test.
	initial begin
		int hold_left;
		int stall_pct;
		hold_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (cycle_count % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Result checker: every taken result is compared with the oldest expectation.
	always @(posedge clk) begin
		aln_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result kind=%0d status=%0d",
						res_ch.kind, res_ch.status);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.kind !== want.kind || res_ch.status !== want.status ||
						res_ch.best_score !== want.score || res_ch.best_row !== want.row ||
						res_ch.best_col !== want.col || res_ch.align_length !== want.len ||
						res_ch.long_symbol !== want.lsym ||
						res_ch.short_symbol !== want.ssym ||
						res_ch.last_column !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display({"mismatch exp kind=%0d st=%0d score=%0d row=%0d col=%0d",
							" len=%0d ls=%0d ss=%0d last=%0d"},
							want.kind, want.status, want.score, want.row, want.col,
							want.len, want.lsym, want.ssym, want.last);
						$display({"         got kind=%0d st=%0d score=%0d row=%0d col=%0d",
							" len=%0d ls=%0d ss=%0d last=%0d"},
							res_ch.kind, res_ch.status, res_ch.best_score, res_ch.best_row,
							res_ch.best_col, res_ch.align_length, res_ch.long_symbol,
							res_ch.short_symbol, res_ch.last_column);
					end
				end
			end
		end
	end

	// Corner cases at the reset register values: empty sequences, reads with
	// nothing to read, unused opcodes, single bases and a long load overflow.
	task automatic test_directed();
		send_request(dast_pkg::OP_ALIGN, 2'd0);
		send_request(dast_pkg::OP_READ, 2'd3);
		send_request(3'd5, 2'd1);
		send_request(3'd6, 2'd2);
		send_request(3'd7, 2'd3);
		send_request(dast_pkg::OP_LOAD_LONG, 2'd3);
		send_request(dast_pkg::OP_ALIGN, 2'd0);
		send_request(dast_pkg::OP_LOAD_SHORT, 2'd0);
		send_request(dast_pkg::OP_LOAD_SHORT, 2'd3);
		send_request(dast_pkg::OP_ALIGN, 2'd1);
		for (int i = 0; i < column_count + 1; i++) send_request(dast_pkg::OP_READ, 2'd2);
		send_request(dast_pkg::OP_CLEAR, 2'd0);
		send_request(dast_pkg::OP_READ, 2'd0);
		send_request(dast_pkg::OP_ALIGN, 2'd0);
		// Overflow: one base too many on the long side; align still uses the held bases.
		for (int i = 0; i <= dast_pkg::MAX_LEN; i++)
			send_request(dast_pkg::OP_LOAD_LONG, 2'(i % 4));
		send_request(dast_pkg::OP_LOAD_SHORT, 2'd1);
		send_request(dast_pkg::OP_LOAD_SHORT, 2'd2);
		send_request(dast_pkg::OP_ALIGN, 2'd0);
		for (int i = 0; i < column_count + 1; i++) send_request(dast_pkg::OP_READ, 2'd1);
		send_request(dast_pkg::OP_CLEAR, 2'd3);
		send_request(dast_pkg::OP_ALIGN, 2'd0);
	endtask

	// Several register settings, the extremes among them, each with a few jobs.
	task automatic test_register_settings();
		write_registers(8'd0, {8{8'h80}}, {8{8'h80}});
		repeat (3) run_alignment($urandom_range(1, 8), $urandom_range(1, 8), 1'b1);
		write_registers(8'd255, {8{8'h7f}}, {8{8'h7f}});
		repeat (3) run_alignment($urandom_range(1, 8), $urandom_range(1, 8), 1'b1);
		write_registers(8'd255, {8{8'h80}}, {8{8'h80}});
		repeat (3) run_alignment($urandom_range(1, 8), $urandom_range(1, 8), 1'b0);
		write_registers(8'd1, 64'hffff_ffff_ffff_ffff, 64'h0);
		repeat (3) run_alignment($urandom_range(1, 8), $urandom_range(1, 8), 1'b0);
	endtask

	// Random jobs with random content, mixed with loose noise requests, and
	// a new random register setting every so often.
	task automatic test_random_jobs();
		int items;
		int since_cfg;
		items = 0;
		since_cfg = 0;
		while (items < 100) begin
			if (since_cfg > 40) begin
				write_registers(($urandom_range(0, 9) == 0) ? 8'd255
					: 8'($urandom_range(0, 6)), random_weights(), random_weights());
				since_cfg = 0;
			end
			sender_gaps = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					logic [2:0] op;
					op = 3'($urandom_range(0, 7));
					send_request(op, 2'($urandom_range(0, 3)));
					if (op <= dast_pkg::OP_CLEAR) items++;
				end
			end else begin
				int llen, slen;
				llen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
				slen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
				run_alignment(llen, slen, $urandom_range(0, 3) == 0);
				items += llen + slen + 2 + column_count;
			end
			since_cfg += 20;
		end
	endtask

	// The receiver holds off while requests keep coming, so the block must stall
	// its input; afterwards the sender pauses until all results are back.
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		wait_for_drain();
		hold_request = 1'b1;
		repeat (4) run_alignment(3, 3, 1'b1);
		wait_for_drain();
		sender_gaps = 1'b1;
	endtask

	// One job at the largest sizes.
	task automatic test_full_size();
		write_registers(8'd2, random_weights(), random_weights());
		run_alignment(dast_pkg::MAX_LEN, dast_pkg::MAX_LEN, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = dast_pkg::OP_LOAD_LONG;
		cmd_ch.base = 2'd0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = dast_pkg::REG_GAP;
		cfg_ch.wdata = 64'd0;
		cycle_count = 0;
		mismatch_count = 0;
		hold_request = 1'b0;
		burst_left = 0;
		sender_gaps = 1'b1;
		gap_reg = 8'd0;
		w_at_reg = 64'd1099511627777;
		w_gc_reg = 64'd72057594037993472;
		long_len = 0;
		short_len = 0;
		overflow_seen = 1'b0;
		column_count = 0;
		read_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_settings();
		test_backpressure();
		test_random_jobs();
		test_full_size();
		wait_for_drain();

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/dast_pkg.sv
rtl/core/dast_if.sv
rtl/core/dast_ctrl.sv
rtl/core/dast_dp.sv
rtl/core/dna_alignment_score_traceback_core.sv
test/tb_dna_alignment_score_traceback_core.sv
